[rtl/slfr_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_pkg
// Shared types and constants of the sync/length frame receiver.
// ----------------------------------------------------------------------------
package slfr_pkg;

   localparam logic [7:0]  SYNC_BYTE       = 8'hAA;
   localparam logic [7:0]  EXT_MARK        = 8'hFF;
   localparam logic [16:0] LEN_POS         = 17'd2;
   localparam logic [16:0] SHORT_LAST_POS  = 17'd5;
   localparam logic [16:0] LONG_LAST_POS   = 17'd9;
   localparam logic [33:0] HDR_SHORT       = 34'd6;
   localparam logic [33:0] HDR_LONG        = 34'd10;
   localparam logic [16:0] LIMIT_RESET     = 17'd4096;
   localparam int          RSP_FIFO_DEPTH  = 8;

   // one result item
   typedef struct packed {
      logic [7:0]  data;
      logic [15:0] pos;
      logic        last;
      logic        too_long;
   } rsp_item_type;

   // results produced by one request, up to two
   typedef struct packed {
      logic         push0;
      logic         push1;
      rsp_item_type item0;
      rsp_item_type item1;
   } push_type;

endpackage

[rtl/slfr_deframe.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_deframe
// Input register, sync hunt, header decode and frame tracking; produces the
// result items of each registered request.
// ----------------------------------------------------------------------------
module slfr_deframe (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 accept,
   input  logic [7:0]           in_byte,
   input  logic [16:0]          frame_limit,
   output slfr_pkg::push_type   push
);

   typedef enum logic [1:0] {
      HUNT   = 2'd0,
      HEADER = 2'd1,
      BODY   = 2'd2
   } phase_type;

   logic        in_valid_ff;
   logic [7:0]  in_byte_ff;
   phase_type   phase_ff, phase_in;
   logic        prev_sync_ff, prev_sync_in;
   logic [16:0] frame_pos_ff, frame_pos_in;
   logic        ext_ff, ext_in;
   logic [31:0] word_count_ff, word_count_in;
   logic [16:0] frame_end_ff, frame_end_in;

   logic [33:0] frame_end_w;
   logic        hdr_last;
   logic        abort;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
      if (accept) begin
         in_byte_ff <= in_byte;
      end
   end

   // decoded length of the frame, valid on the last header byte
   assign frame_end_w = {1'b0, word_count_ff, 1'b0} + (ext_ff ? slfr_pkg::HDR_LONG
                                                               : slfr_pkg::HDR_SHORT);
   assign hdr_last    = ext_ff ? (frame_pos_ff == slfr_pkg::LONG_LAST_POS)
                               : (frame_pos_ff == slfr_pkg::SHORT_LAST_POS);
   assign abort       = frame_end_w > {17'd0, frame_limit};

   // frame tracking
   always_comb begin
      phase_in      = phase_ff;
      prev_sync_in  = prev_sync_ff;
      frame_pos_in  = frame_pos_ff;
      ext_in        = ext_ff;
      word_count_in = word_count_ff;
      frame_end_in  = frame_end_ff;
      push          = '0;
      push.item0.data = in_byte_ff;
      push.item0.pos  = frame_pos_ff[15:0];
      push.item1.data = slfr_pkg::SYNC_BYTE;
      push.item1.pos  = 16'd1;

      if (in_valid_ff) begin
         unique case (phase_ff)
            HEADER: begin
               push.push0   = 1'b1;
               frame_pos_in = frame_pos_ff + 17'd1;
               // length byte
               if (frame_pos_ff == slfr_pkg::LEN_POS) begin
                  ext_in        = (in_byte_ff == slfr_pkg::EXT_MARK);
                  word_count_in = ext_in ? 32'd0 : {24'd0, in_byte_ff};
               end
               // extended count, little-endian at header bytes 4 to 7
               if (ext_ff && frame_pos_ff[16:2] == 15'd1) begin
                  unique case (frame_pos_ff[1:0])
                     2'd0: word_count_in[7:0]   = in_byte_ff;
                     2'd1: word_count_in[15:8]  = in_byte_ff;
                     2'd2: word_count_in[23:16] = in_byte_ff;
                     2'd3: word_count_in[31:24] = in_byte_ff;
                     default: word_count_in = word_count_ff;
                  endcase
               end
               // limit check and phase change on the last header byte
               if (hdr_last) begin
                  frame_end_in = frame_end_w[16:0];
                  if (abort) begin
                     push.item0.last     = 1'b1;
                     push.item0.too_long = 1'b1;
                     phase_in            = HUNT;
                     prev_sync_in        = 1'b0;
                  end else if (word_count_ff == 32'd0) begin
                     push.item0.last = 1'b1;
                     phase_in        = HUNT;
                     prev_sync_in    = 1'b0;
                  end else begin
                     phase_in = BODY;
                  end
               end
            end
            BODY: begin
               push.push0   = 1'b1;
               frame_pos_in = frame_pos_ff + 17'd1;
               if ({1'b0, frame_pos_ff} + 18'd1 >= {1'b0, frame_end_ff}) begin
                  push.item0.last = 1'b1;
                  phase_in        = HUNT;
                  prev_sync_in    = 1'b0;
               end
            end
            default: begin
               // hunting, also the unused phase code
               if (prev_sync_ff && in_byte_ff == slfr_pkg::SYNC_BYTE) begin
                  push.push0      = 1'b1;
                  push.push1      = 1'b1;
                  push.item0.data = slfr_pkg::SYNC_BYTE;
                  push.item0.pos  = 16'd0;
                  phase_in        = HEADER;
                  prev_sync_in    = 1'b0;
                  frame_pos_in    = 17'd2;
                  ext_in          = 1'b0;
                  word_count_in   = 32'd0;
                  frame_end_in    = 17'd0;
               end else begin
                  phase_in     = HUNT;
                  prev_sync_in = (in_byte_ff == slfr_pkg::SYNC_BYTE);
               end
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= HUNT;
         prev_sync_ff  <= 1'b0;
         frame_pos_ff  <= 17'd0;
         ext_ff        <= 1'b0;
         word_count_ff <= 32'd0;
         frame_end_ff  <= 17'd0;
      end else begin
         phase_ff      <= phase_in;
         prev_sync_ff  <= prev_sync_in;
         frame_pos_ff  <= frame_pos_in;
         ext_ff        <= ext_in;
         word_count_ff <= word_count_in;
         frame_end_ff  <= frame_end_in;
      end
   end

endmodule

[rtl/slfr_rsp_fifo.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_rsp_fifo
// Result queue in flip-flops: takes up to two items a cycle, gives one.
// ----------------------------------------------------------------------------
module slfr_rsp_fifo #(
   parameter int DEPTH = slfr_pkg::RSP_FIFO_DEPTH,
   localparam int PTR_W = $clog2(DEPTH),
   localparam int CNT_W = $clog2(DEPTH + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  slfr_pkg::push_type       push,
   input  logic                     pop,
   output logic                     not_empty,
   output slfr_pkg::rsp_item_type   head,
   output logic [CNT_W-1:0]         count
);

   slfr_pkg::rsp_item_type mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]       count_ff, count_in;
   logic                   do_pop;

   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign do_pop    = pop && not_empty;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + PTR_W'(push.push0) + PTR_W'(push.push1);
      rd_ptr_in = rd_ptr_ff + PTR_W'(do_pop);
      count_in  = count_ff + CNT_W'(push.push0) + CNT_W'(push.push1) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry writes, second item only comes with the first
   always_ff @(posedge clock) begin
      if (push.push0) begin
         mem_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.push1) begin
         mem_ff[wr_ptr_ff + PTR_W'(1)] <= push.item1;
      end
   end

endmodule

[rtl/sync_length_frame_receiver_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sync_length_frame_receiver_top
// Sync-word, length-prefixed frame receiver for a byte stream.
// ----------------------------------------------------------------------------
// One received byte is taken per clock cycle while req_tready is high. Each
// request goes through an input register and the header/frame decode logic,
// and its results are written into a small result queue that gives them out
// in order. A completed sync pair gives two results (positions 0 and 1),
// every header and payload byte one, and hunting bytes none. The queue of
// RSP_DEPTH entries takes the sync pair's extra result, so req_tready only
// drops while the queue holds more than RSP_DEPTH - 4 entries, that is when
// the consumer holds rsp_tready low. csr writes of frame_limit are taken in
// any cycle.
module sync_length_frame_receiver_top #(
   parameter int RSP_DEPTH = slfr_pkg::RSP_FIFO_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] in_byte
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,    // [7:0] out_byte, [23:8] byte_pos
   output logic        rsp_tlast,    // is_last
   output logic [0:0]  rsp_tuser,    // [0] too_long
   // configuration write
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [16:0] csr_data      // [16:0] frame_limit
);

   localparam int CNT_W = $clog2(RSP_DEPTH + 1);

   logic [16:0]            frame_limit_ff;
   logic                   req_accept;
   slfr_pkg::push_type     push;
   slfr_pkg::rsp_item_type head;
   logic [CNT_W-1:0]       fill;

   // frame limit register
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_limit_ff <= slfr_pkg::LIMIT_RESET;
      end else if (csr_valid) begin
         frame_limit_ff <= csr_data;
      end
   end

   // room for the request in flight and the new one
   assign req_tready = (fill <= CNT_W'(RSP_DEPTH - 4));
   assign req_accept = req_tvalid && req_tready;

   slfr_deframe u_deframe (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .in_byte     (req_tdata),
      .frame_limit (frame_limit_ff),
      .push        (push)
   );

   slfr_rsp_fifo #(
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (rsp_tready),
      .not_empty (rsp_tvalid),
      .head      (head),
      .count     (fill)
   );

   // result packing
   assign rsp_tdata = {head.pos, head.data};
   assign rsp_tlast = head.last;
   assign rsp_tuser = head.too_long;

endmodule

[rtl/slfr_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slfr_checker
// Port-level checks of the frame receiver, bound to the top level.
// ----------------------------------------------------------------------------
module slfr_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast,
   input logic [0:0]  rsp_tuser
);

   // queue empties on reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)
                                    && $stable(rsp_tlast) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // an abort always closes the frame
   a_abort_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("too_long without last");

   // aborts happen only on the last header byte
   a_abort_pos: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> (rsp_tdata[23:8] == 16'd5 || rsp_tdata[23:8] == 16'd9))
      else $error("abort away from header end");

endmodule

bind sync_length_frame_receiver_top slfr_checker u_slfr_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser)
);
